// ===== rtl/gdda_pkg.sv =====
// ---------------------------------------------------------------------------
// gdda_pkg: shared types and constants for the grid ray caster
// Sequencer states, opcodes, register indexes and the divider request.
// ---------------------------------------------------------------------------
package gdda_pkg;

   localparam int CAM_W  = 26;   // signed Q.14 camera offset
   localparam int R_W    = 29;   // signed Q.14 ray component
   localparam int DVS_W  = 29;   // unsigned divisor
   localparam int DIV_W  = 32;   // dividend / quotient

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [2:0] CSR_POS_X   = 3'd0;
   localparam logic [2:0] CSR_POS_Y   = 3'd1;
   localparam logic [2:0] CSR_DIR_X   = 3'd2;
   localparam logic [2:0] CSR_DIR_Y   = 3'd3;
   localparam logic [2:0] CSR_PLANE_X = 3'd4;
   localparam logic [2:0] CSR_PLANE_Y = 3'd5;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CAM,
      S_RAY_X,
      S_RAY_Y,
      S_DIV_X,
      S_DIV_Y,
      S_SIDE_X,
      S_SIDE_Y,
      S_STEP,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

endpackage

// ===== rtl/gdda_div.sv =====
// ---------------------------------------------------------------------------
// gdda_div: restoring divider, one quotient bit per cycle
// Unsigned 32-bit dividend by 29-bit divisor; done pulses with the quotient.
// ---------------------------------------------------------------------------
module gdda_div (
   input  logic                      clock,
   input  logic                      reset,
   input  gdda_pkg::div_req_type     div_req,
   output logic                      div_done,
   output logic [gdda_pkg::DIV_W-1:0] div_quo
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [gdda_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [gdda_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [gdda_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [gdda_pkg::DVS_W:0]     trial;
   logic                         ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[gdda_pkg::DIV_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? gdda_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                     : trial[gdda_pkg::DVS_W-1:0];
         quo_in = {quo_ff[gdda_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

// ===== rtl/grid_ray_dda_caster_top.sv =====
// Cast: two reciprocals on the shared divider (skipped for a zero ray component),
// setup and load states, then grid steps, each with a map read; a step off the
// map ends the cast without checking the map. Map writes are done in the idle state.
// One transaction in flight; a waiting result frees the input.
// Reset: synchronous; then a clearing pass over all 4**clog2(MAP_DIM) entries
// (4096 at MAP_DIM 64) zeroes the wall map before req_ready rises.
// ---------------------------------------------------------------------------
// grid_ray_dda_caster_top: fixed-point DDA ray caster over a wall map
// Sequencer around a shared divider and multiplier; wall map in block RAM.
// ---------------------------------------------------------------------------
module grid_ray_dda_caster_top #(
   parameter int SCREEN_WIDTH = 1024,
   parameter int MAP_DIM      = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [9:0]  req_column,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic        req_cell_wall,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_ray_column,
   output logic [5:0]  rsp_hit_x,
   output logic [5:0]  rsp_hit_y,
   output logic        rsp_hit_side,
   output logic [31:0] rsp_side_x,
   output logic [31:0] rsp_side_y,
   output logic [31:0] rsp_delta_x,
   output logic [31:0] rsp_delta_y,
   output logic        rsp_step_x_neg,
   output logic        rsp_step_y_neg,
   output logic        rsp_off_map,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_data
);

   localparam int AW        = $clog2(MAP_DIM);
   localparam int MA        = 2 * AW;
   localparam int MAP_DEPTH = 1 << MA;
   localparam int CW        = ((AW > 6) ? AW : 6) + 2;
   localparam int CAM_W     = gdda_pkg::CAM_W;
   localparam int R_W       = gdda_pkg::R_W;
   // rounded-up 2^37 / SCREEN_WIDTH: col * recip >> 22 is exact for col < 1024
   localparam logic [36:0] CAM_RECIP =
      37'(((64'd1 << 37) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

   // configuration
   logic [21:0]        pos_x_ff, pos_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   gdda_pkg::state_type state_ff, state_in;
   logic               div_wait_ff, div_wait_in;
   logic [MA-1:0]      clr_cnt_ff, clr_cnt_in;

   logic [9:0]               col_ff;
   logic signed [CAM_W-1:0]  cam_ff;
   logic signed [R_W-1:0]    rx_ff, ry_ff;
   logic [31:0]              ddx_ff, ddy_ff, sdx_ff, sdy_ff;
   logic signed [CW-1:0]     mx_ff, my_ff;
   logic                     side_ff;

   gdda_pkg::div_req_type    div_req;
   logic                     div_done;
   logic [31:0]              div_q;

   logic                     map_mem [MAP_DEPTH];
   logic                     mem_we, mem_wd, mem_rd_ff;
   logic [MA-1:0]            mem_wa, mem_ra;

   logic signed [17:0]       mul_a;
   logic signed [32:0]       mul_b;
   logic signed [50:0]       mul_p;
   logic [32:0]              side_p;
   logic [46:0]              cam_p;

   logic                     nx, ny, wr_ok, load_rsp;
   logic [16:0]              span_x, span_y;
   logic                     step_x, off_n;
   logic signed [CW-1:0]     mx_n, my_n;
   logic [32:0]              sum_x, sum_y;
   logic [31:0]              sdx_n, sdy_n;
   logic [R_W-1:0]           abs_rx, abs_ry;

   logic                     rsp_valid_ff;
   logic [9:0]               rsp_col_ff;
   logic [5:0]               rsp_hx_ff, rsp_hy_ff;
   logic                     rsp_side_ff, rsp_nx_ff, rsp_ny_ff, rsp_off_ff;
   logic [31:0]              rsp_sdx_ff, rsp_sdy_ff, rsp_ddx_ff, rsp_ddy_ff;

   gdda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_q)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 22'd98304;
         pos_y_ff   <= 22'd98304;
         dir_x_ff   <= 16'sd16384;
         dir_y_ff   <= 16'sd0;
         plane_x_ff <= 16'sd0;
         plane_y_ff <= 16'sd10813;
      end else if (csr_valid) begin
         unique case (csr_index)
            gdda_pkg::CSR_POS_X:   pos_x_ff   <= csr_data;
            gdda_pkg::CSR_POS_Y:   pos_y_ff   <= csr_data;
            gdda_pkg::CSR_DIR_X:   dir_x_ff   <= csr_data[15:0];
            gdda_pkg::CSR_DIR_Y:   dir_y_ff   <= csr_data[15:0];
            gdda_pkg::CSR_PLANE_X: plane_x_ff <= csr_data[15:0];
            gdda_pkg::CSR_PLANE_Y: plane_y_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // datapath helpers
   assign nx     = rx_ff[R_W-1];
   assign ny     = ry_ff[R_W-1];
   assign abs_rx = nx ? R_W'(-rx_ff) : R_W'(rx_ff);
   assign abs_ry = ny ? R_W'(-ry_ff) : R_W'(ry_ff);
   assign span_x = nx ? {1'b0, pos_x_ff[15:0]} : 17'h10000 - {1'b0, pos_x_ff[15:0]};
   assign span_y = ny ? {1'b0, pos_y_ff[15:0]} : 17'h10000 - {1'b0, pos_y_ff[15:0]};
   assign wr_ok  = (9'(req_cell_x) < 9'(MAP_DIM)) && (9'(req_cell_y) < 9'(MAP_DIM));
   assign cam_p  = col_ff * CAM_RECIP;

   // shared multiplier: plane*cam for the ray, span*delta for first side
   always_comb begin
      unique case (state_ff)
         gdda_pkg::S_RAY_X: begin
            mul_a = 18'(plane_x_ff);
            mul_b = 33'(cam_ff);
         end
         gdda_pkg::S_RAY_Y: begin
            mul_a = 18'(plane_y_ff);
            mul_b = 33'(cam_ff);
         end
         gdda_pkg::S_SIDE_X: begin
            mul_a = $signed({1'b0, span_x});
            mul_b = $signed({1'b0, ddx_ff});
         end
         default: begin
            mul_a = $signed({1'b0, span_y});
            mul_b = $signed({1'b0, ddy_ff});
         end
      endcase
      mul_p  = mul_a * mul_b;
      side_p = mul_p[48:16];
   end

   // one grid step
   always_comb begin
      step_x = sdx_ff < sdy_ff;
      sum_x  = {1'b0, sdx_ff} + {1'b0, ddx_ff};
      sum_y  = {1'b0, sdy_ff} + {1'b0, ddy_ff};
      mx_n   = mx_ff;
      my_n   = my_ff;
      sdx_n  = sdx_ff;
      sdy_n  = sdy_ff;
      if (step_x) begin
         mx_n  = nx ? mx_ff - CW'(1) : mx_ff + CW'(1);
         sdx_n = sum_x[32] ? '1 : sum_x[31:0];
      end else begin
         my_n  = ny ? my_ff - CW'(1) : my_ff + CW'(1);
         sdy_n = sum_y[32] ? '1 : sum_y[31:0];
      end
      off_n  = (mx_n < 0) || (mx_n >= CW'(MAP_DIM)) ||
               (my_n < 0) || (my_n >= CW'(MAP_DIM));
      mem_ra = {my_n[AW-1:0], mx_n[AW-1:0]};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      div_wait_in  = div_wait_ff;
      clr_cnt_in   = clr_cnt_ff;
      div_req      = '0;
      mem_we       = 1'b0;
      mem_wa       = {AW'(req_cell_y), AW'(req_cell_x)};
      mem_wd       = req_cell_wall;
      load_rsp     = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         gdda_pkg::S_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = 1'b0;
            clr_cnt_in = clr_cnt_ff + MA'(1);
            if (&clr_cnt_ff) state_in = gdda_pkg::S_IDLE;
         end
         gdda_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == gdda_pkg::OP_CAST) state_in = gdda_pkg::S_CAM;
               else mem_we = wr_ok;
            end
         end
         gdda_pkg::S_CAM:   state_in = gdda_pkg::S_RAY_X;
         gdda_pkg::S_RAY_X: state_in = gdda_pkg::S_RAY_Y;
         gdda_pkg::S_RAY_Y: state_in = gdda_pkg::S_DIV_X;
         gdda_pkg::S_DIV_X: begin
            div_req.dividend = 32'h4000_0000;
            div_req.divisor  = gdda_pkg::DVS_W'(abs_rx);
            if (rx_ff == '0) state_in = gdda_pkg::S_DIV_Y;
            else if (!div_wait_ff) begin
               div_req.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_done) begin
               div_wait_in = 1'b0;
               state_in    = gdda_pkg::S_DIV_Y;
            end
         end
         gdda_pkg::S_DIV_Y: begin
            div_req.dividend = 32'h4000_0000;
            div_req.divisor  = gdda_pkg::DVS_W'(abs_ry);
            if (ry_ff == '0) state_in = gdda_pkg::S_SIDE_X;
            else if (!div_wait_ff) begin
               div_req.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_done) begin
               div_wait_in = 1'b0;
               state_in    = gdda_pkg::S_SIDE_X;
            end
         end
         gdda_pkg::S_SIDE_X: state_in = gdda_pkg::S_SIDE_Y;
         gdda_pkg::S_SIDE_Y: state_in = gdda_pkg::S_STEP;
         gdda_pkg::S_STEP:   state_in = off_n ? gdda_pkg::S_DONE : gdda_pkg::S_CHECK;
         gdda_pkg::S_CHECK:  state_in = mem_rd_ff ? gdda_pkg::S_DONE : gdda_pkg::S_STEP;
         gdda_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = gdda_pkg::S_IDLE;
            end
         end
         default: state_in = gdda_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gdda_pkg::S_CLEAR;
         div_wait_ff <= 1'b0;
         clr_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         div_wait_ff <= div_wait_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // wall map
   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_wa] <= mem_wd;
      mem_rd_ff <= map_mem[mem_ra];
   end

   // cast datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         gdda_pkg::S_IDLE: col_ff <= req_column;
         gdda_pkg::S_CAM:
            cam_ff <= $signed({1'b0, cam_p[46:22]}) - CAM_W'(16384);
         gdda_pkg::S_RAY_X: rx_ff <= R_W'(dir_x_ff) + R_W'(mul_p >>> 14);
         gdda_pkg::S_RAY_Y: ry_ff <= R_W'(dir_y_ff) + R_W'(mul_p >>> 14);
         gdda_pkg::S_DIV_X:
            if (rx_ff == '0) ddx_ff <= '1;
            else if (div_wait_ff && div_done) ddx_ff <= div_q;
         gdda_pkg::S_DIV_Y:
            if (ry_ff == '0) ddy_ff <= '1;
            else if (div_wait_ff && div_done) ddy_ff <= div_q;
         gdda_pkg::S_SIDE_X: begin
            sdx_ff <= side_p[32] ? '1 : side_p[31:0];
            mx_ff  <= CW'({1'b0, pos_x_ff[21:16]});
            my_ff  <= CW'({1'b0, pos_y_ff[21:16]});
         end
         gdda_pkg::S_SIDE_Y: sdy_ff <= side_p[32] ? '1 : side_p[31:0];
         gdda_pkg::S_STEP: begin
            mx_ff   <= mx_n;
            my_ff   <= my_n;
            sdx_ff  <= sdx_n;
            sdy_ff  <= sdy_n;
            side_ff <= ~step_x;
         end
         default: ;
      endcase
   end

   // result register; off-map is known from the coordinates themselves
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (load_rsp) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (load_rsp) begin
         rsp_col_ff  <= col_ff;
         rsp_hx_ff   <= mx_ff[5:0];
         rsp_hy_ff   <= my_ff[5:0];
         rsp_side_ff <= side_ff;
         rsp_sdx_ff  <= sdx_ff;
         rsp_sdy_ff  <= sdy_ff;
         rsp_ddx_ff  <= ddx_ff;
         rsp_ddy_ff  <= ddy_ff;
         rsp_nx_ff   <= nx;
         rsp_ny_ff   <= ny;
         rsp_off_ff  <= (mx_ff < 0) || (mx_ff >= CW'(MAP_DIM)) ||
                        (my_ff < 0) || (my_ff >= CW'(MAP_DIM));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ray_column   = rsp_col_ff;
   assign rsp_hit_x        = rsp_hx_ff;
   assign rsp_hit_y        = rsp_hy_ff;
   assign rsp_hit_side     = rsp_side_ff;
   assign rsp_side_x       = rsp_sdx_ff;
   assign rsp_side_y       = rsp_sdy_ff;
   assign rsp_delta_x      = rsp_ddx_ff;
   assign rsp_delta_y      = rsp_ddy_ff;
   assign rsp_step_x_neg   = rsp_nx_ff;
   assign rsp_step_y_neg   = rsp_ny_ff;
   assign rsp_off_map      = rsp_off_ff;

`ifndef ASSERT_OFF
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdda_pkg::S_CLEAR |-> !req_ready)
      else $error("input taken during map clear");

   a_cast_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == gdda_pkg::OP_CAST
      |=> state_ff == gdda_pkg::S_CAM)
      else $error("cast did not start the sequencer");

   a_check_in_map: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdda_pkg::S_CHECK |-> mx_ff >= 0 && my_ff >= 0 &&
      mx_ff < CW'(MAP_DIM) && my_ff < CW'(MAP_DIM))
      else $error("map read outside the map");

   a_no_load_over_result: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the grid ray caster
// Map writes and ray casts go in through a queue-fed driver; a monitor checks
// every returned ray against a fixed-point DDA walk kept in step here.
// ---------------------------------------------------------------------------
module tb;

   localparam int SCREEN_WIDTH = 1024;
   localparam int MAP_DIM      = 64;
   localparam int STALL_LIMIT  = 40000;
   // indexes past the register list, written to check they are ignored
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic       op;
      logic [9:0] column;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic       cell_wall;
   } cast_req_type;

   typedef struct packed {
      logic [9:0]  column;
      logic [5:0]  hit_x;
      logic [5:0]  hit_y;
      logic        side;
      logic [31:0] sdx;
      logic [31:0] sdy;
      logic [31:0] ddx;
      logic [31:0] ddy;
      logic        nx;
      logic        ny;
      logic        off;
   } ray_hit_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic req_op = 0;
   logic [9:0] req_column = 0;
   logic [5:0] req_cell_x = 0, req_cell_y = 0;
   logic req_cell_wall = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [9:0] rsp_ray_column;
   logic [5:0] rsp_hit_x, rsp_hit_y;
   logic rsp_hit_side, rsp_step_x_neg, rsp_step_y_neg, rsp_off_map;
   logic [31:0] rsp_side_x, rsp_side_y, rsp_delta_x, rsp_delta_y;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [21:0] csr_data = 0;

   grid_ray_dda_caster_top #(.SCREEN_WIDTH(SCREEN_WIDTH), .MAP_DIM(MAP_DIM)) uut (.*);

   always #10 clock = ~clock;

   // mirror of the block's registers and wall map
   logic [21:0] vpos_x, vpos_y;
   longint vdir_x, vdir_y, vplane_x, vplane_y;
   bit vmap [MAP_DIM*MAP_DIM];

   cast_req_type pending_reqs[$];
   ray_hit_type  expected_hits[$];
   int  errors = 0;
   int  idle_cnt = 0;
   bit  stim_done = 0;

   function automatic longint floor_div14(longint v);
      if (v >= 0) return v >>> 14;
      return -((-v + 16383) >>> 14);
   endfunction

   function automatic logic [31:0] recip_abs(longint r);
      longint m, q;
      if (r == 0) return '1;
      m = r < 0 ? -r : r;
      q = (longint'(1) << 30) / m;
      return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [31:0] start_side(bit neg, logic [21:0] p, logic [31:0] d);
      longint span, prod;
      span = neg ? longint'(p[15:0]) : 65536 - longint'(p[15:0]);
      prod = (span * longint'(d)) >>> 16;
      return prod > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : prod[31:0];
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = a + b;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic ray_hit_type cast_ray(logic [9:0] col);
      ray_hit_type h;
      longint cam, rx, ry, mx, my;
      bit done;
      cam = ((longint'(col) << 15) / SCREEN_WIDTH) - 16384;
      rx = vdir_x + floor_div14(vplane_x * cam);
      ry = vdir_y + floor_div14(vplane_y * cam);
      h.column = col;
      h.ddx = recip_abs(rx);
      h.ddy = recip_abs(ry);
      h.nx = rx < 0;
      h.ny = ry < 0;
      mx = vpos_x >> 16;
      my = vpos_y >> 16;
      h.sdx = start_side(h.nx, vpos_x, h.ddx);
      h.sdy = start_side(h.ny, vpos_y, h.ddy);
      h.off = 0;
      h.side = 0;
      done = 0;
      while (!done) begin
         if (h.sdx < h.sdy) begin
            h.sdx = add_sat(h.sdx, h.ddx);
            mx += h.nx ? -1 : 1;
            h.side = 0;
         end else begin
            h.sdy = add_sat(h.sdy, h.ddy);
            my += h.ny ? -1 : 1;
            h.side = 1;
         end
         if (mx < 0 || mx >= MAP_DIM || my < 0 || my >= MAP_DIM) begin
            h.off = 1;
            done = 1;
         end else if (vmap[my*MAP_DIM+mx]) begin
            done = 1;
         end
      end
      h.hit_x = mx[5:0];
      h.hit_y = my[5:0];
      return h;
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_op == gdda_pkg::OP_WRITE) begin
               if (req_cell_x < MAP_DIM && req_cell_y < MAP_DIM)
                  vmap[req_cell_y*MAP_DIM+req_cell_x] = req_cell_wall;
            end else
               expected_hits.push_back(cast_ray(req_column));
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 0;
            end else if (pending_reqs.size() > 0) begin
               cast_req_type r;
               r = pending_reqs.pop_front();
               {req_op, req_column, req_cell_x, req_cell_y, req_cell_wall} <= r;
               req_valid <= 1;
               req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t unexpected ray result column %0d", $time, rsp_ray_column);
               errors++;
            end else begin
               ray_hit_type e, a;
               e = expected_hits.pop_front();
               a = {rsp_ray_column, rsp_hit_x, rsp_hit_y, rsp_hit_side,
                    rsp_side_x, rsp_side_y, rsp_delta_x,
                    rsp_delta_y, rsp_step_x_neg, rsp_step_y_neg, rsp_off_map};
               if (a.column !== e.column) begin
                  $display("%0t column exp %0d got %0d", $time, e.column, a.column); errors++; end
               if (a.hit_x !== e.hit_x) begin
                  $display("%0t hit_x exp %0d got %0d", $time, e.hit_x, a.hit_x); errors++; end
               if (a.hit_y !== e.hit_y) begin
                  $display("%0t hit_y exp %0d got %0d", $time, e.hit_y, a.hit_y); errors++; end
               if (a.side !== e.side) begin
                  $display("%0t hit_side exp %0d got %0d", $time, e.side, a.side); errors++; end
               if (a.sdx !== e.sdx) begin
                  $display("%0t side_x exp %h got %h", $time, e.sdx, a.sdx); errors++; end
               if (a.sdy !== e.sdy) begin
                  $display("%0t side_y exp %h got %h", $time, e.sdy, a.sdy); errors++; end
               if (a.ddx !== e.ddx) begin
                  $display("%0t delta_x exp %h got %h", $time, e.ddx, a.ddx); errors++; end
               if (a.ddy !== e.ddy) begin
                  $display("%0t delta_y exp %h got %h", $time, e.ddy, a.ddy); errors++; end
               if (a.nx !== e.nx) begin
                  $display("%0t step_x_neg exp %0d got %0d", $time, e.nx, a.nx); errors++; end
               if (a.ny !== e.ny) begin
                  $display("%0t step_y_neg exp %0d got %0d", $time, e.ny, a.ny); errors++; end
               if (a.off !== e.off) begin
                  $display("%0t off_map exp %0d got %0d", $time, e.off, a.off); errors++; end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if (rsp_valid && rsp_ready)
               rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cnt <= 0;
      else if (!stim_done) begin
         idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= STALL_LIMIT) begin
            $display("FAIL grid_ray_dda_caster_top");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [21:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 0;
      case (idx)
         gdda_pkg::CSR_POS_X:   vpos_x = val;
         gdda_pkg::CSR_POS_Y:   vpos_y = val;
         gdda_pkg::CSR_DIR_X:   vdir_x = longint'($signed(val[15:0]));
         gdda_pkg::CSR_DIR_Y:   vdir_y = longint'($signed(val[15:0]));
         gdda_pkg::CSR_PLANE_X: vplane_x = longint'($signed(val[15:0]));
         gdda_pkg::CSR_PLANE_Y: vplane_y = longint'($signed(val[15:0]));
         default: ;
      endcase
   endtask

   task automatic push_write(int x, int y, bit w);
      cast_req_type r;
      r = '0;
      r.op = gdda_pkg::OP_WRITE;
      r.cell_x = 6'(x);
      r.cell_y = 6'(y);
      r.cell_wall = w;
      r.column = 10'($urandom);
      pending_reqs.push_back(r);
   endtask

   task automatic push_cast(int col);
      cast_req_type r;
      r = 24'($urandom);
      r.op = gdda_pkg::OP_CAST;
      r.column = 10'(col);
      pending_reqs.push_back(r);
   endtask

   // wait for the block to drain before touching the registers
   task automatic drain;
      wait (pending_reqs.size() == 0 && expected_hits.size() == 0 && !req_valid);
      repeat (400) @(posedge clock);
   endtask

   task automatic random_view(bit extreme);
      if (extreme) begin
         write_reg(gdda_pkg::CSR_POS_X, $urandom_range(0, 1) ? 22'h3FFFFF : 22'h0);
         write_reg(gdda_pkg::CSR_POS_Y, $urandom_range(0, 1) ? 22'h3FFFFF : 22'h0);
         write_reg(gdda_pkg::CSR_DIR_X, $urandom_range(0, 1) ? 22'h8000 : 22'h7FFF);
         write_reg(gdda_pkg::CSR_DIR_Y, $urandom_range(0, 1) ? 22'h8000 : 22'h7FFF);
         write_reg(gdda_pkg::CSR_PLANE_X, $urandom_range(0, 1) ? 22'h8000 : 22'h7FFF);
         write_reg(gdda_pkg::CSR_PLANE_Y, $urandom_range(0, 1) ? 22'h8000 : 22'h0);
      end else begin
         // full-range view registers
         write_reg(gdda_pkg::CSR_POS_X, 22'($urandom));
         write_reg(gdda_pkg::CSR_POS_Y, 22'($urandom));
         write_reg(gdda_pkg::CSR_DIR_X, 22'($urandom));
         write_reg(gdda_pkg::CSR_DIR_Y, 22'($urandom));
         write_reg(gdda_pkg::CSR_PLANE_X, 22'($urandom));
         write_reg(gdda_pkg::CSR_PLANE_Y, 22'($urandom));
      end
   endtask

   initial begin
      vpos_x = 98304; vpos_y = 98304;
      vdir_x = 16384; vdir_y = 0; vplane_x = 0; vplane_y = 10813;
      foreach (vmap[i]) vmap[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: reset view, edge columns, walls, start inside a wall
      push_cast(0); push_cast(512); push_cast(1023);
      push_write(3, 1, 1); push_write(1, 1, 1); push_write(63, 63, 1);
      push_write(0, 0, 1); push_write(3, 1, 0); push_write(4, 1, 1);
      push_cast(0); push_cast(511); push_cast(1023);
      drain;
      write_reg(gdda_pkg::CSR_DIR_X, 22'h0);       // ray x zero at every column
      write_reg(gdda_pkg::CSR_PLANE_X, 22'h0);
      write_reg(gdda_pkg::CSR_DIR_Y, 22'h3FC000);  // -1.0
      write_reg(gdda_pkg::CSR_PLANE_Y, 22'h0);
      push_cast(0); push_cast(1023);
      drain;
      write_reg(gdda_pkg::CSR_POS_X, 22'h3FFFFF);  // far map corner
      write_reg(gdda_pkg::CSR_POS_Y, 22'h0);
      write_reg(gdda_pkg::CSR_DIR_X, 22'h8000);
      write_reg(gdda_pkg::CSR_DIR_Y, 22'h7FFF);
      write_reg(gdda_pkg::CSR_PLANE_X, 22'h7FFF);
      write_reg(gdda_pkg::CSR_PLANE_Y, 22'h8000);
      write_reg(CSR_SPARE_LO, 22'h15555);          // unused index, ignored
      write_reg(CSR_SPARE_HI, 22'h2AAAA);
      push_cast(0); push_cast(1023); push_cast(300);
      drain;

      // random phases: map writes mixed at random among casts
      for (int ph = 0; ph < 12; ph++) begin
         random_view(ph % 4 == 3);
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(0, 3) == 0)
               push_write($urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 2) != 0);
            else
               push_cast($urandom_range(0, 1023));
         end
         drain;
      end
      stim_done = 1;
      if (errors == 0)
         $display("PASS grid_ray_dda_caster_top");
      else
         $display("FAIL grid_ray_dda_caster_top");
      $finish;
   end
endmodule

// ===== grid_ray_dda_caster_top.f =====
rtl/gdda_pkg.sv
rtl/gdda_div.sv
rtl/grid_ray_dda_caster_top.sv
bench/tb.sv
